FILE: rtl/srne_pkg.sv
`default_nettype none

package srne_pkg;

  // default sizes
  localparam int WEIGHT_COUNT_DEF = 1024;
  localparam int BATCH_SLOTS_DEF  = 128;

  // item opcodes
  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_DELTA = 3'd2;
  localparam logic [2:0] MODE_BWD   = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BIAS  = 2'd0;
  localparam logic [1:0] CFG_KIND  = 2'd1;
  localparam logic [1:0] CFG_LRATE = 2'd2;
  localparam logic [1:0] CFG_ADAM  = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic [6:0]         slot;
    logic [9:0]         index;
    logic signed [31:0] value;
    logic               first;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] activation;
    logic               gradient_flag;
    logic signed [31:0] gradient_value;
    logic signed [31:0] bias_sum;
    logic [7:0]         active_slots;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clip_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_FWD_ADD,
    ST_FWD_END,
    ST_BK_CLIP1,
    ST_BK_MUL2,
    ST_BK_CLIP2,
    ST_BK_GRAD,
    ST_BK_CLIPB,
    ST_BK_BIAS,
    ST_BK_OUT
  } state_t;

  // saturate a wide signed value to 32 bits
  function automatic clip_t sat32(input logic signed [63:0] v);
    clip_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sparse_relu_neuron_engine.sv
`default_nettype none

// Channel   Ports                          Handshake
// input     in_item                        start & !busy accepts one item
// result    out_item                       out_valid, one cycle, no back-pressure
// config    cfg_we, cfg_index, cfg_wdata   write when cfg_we is high
//
// Items run one at a time through a read / modify / write sequencer on the
// weight, gradient and slot memories (registered reads, one shared 32x33
// multiplier). A backward item on an inactive slot ends after the execute
// state; Adam mode skips the learning-rate scale, and the last element adds
// the bias term.
// After reset a clearing pass zeroes the gradient store with busy high.
// Results leave on a one-cycle strobe; the receiver cannot stall.

module sparse_relu_neuron_engine #(
  parameter int WEIGHT_COUNT = srne_pkg::WEIGHT_COUNT_DEF,
  parameter int BATCH_SLOTS  = srne_pkg::BATCH_SLOTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  srne_pkg::in_item_t  in_item,
  output logic                out_valid,
  output srne_pkg::out_item_t out_item,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_index,
  input  wire [31:0]          cfg_wdata
);

  localparam int AW = $clog2(WEIGHT_COUNT);
  localparam int SW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
  localparam int CW = $clog2(BATCH_SLOTS + 1);

  srne_pkg::state_t state_r, state_nxt;
  srne_pkg::in_item_t item_r;
  srne_pkg::out_item_t out_r;
  logic out_valid_r;

  // configuration
  logic signed [31:0] bias_value_r;
  logic               act_kind_r;
  logic [23:0]        lrate_r;
  logic               adam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_value_r <= '0;
      act_kind_r   <= 1'b0;
      lrate_r      <= 24'd655;
      adam_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srne_pkg::CFG_BIAS:  bias_value_r <= cfg_wdata;
        srne_pkg::CFG_KIND:  act_kind_r   <= cfg_wdata[0];
        srne_pkg::CFG_LRATE: lrate_r      <= cfg_wdata[23:0];
        srne_pkg::CFG_ADAM:  adam_r       <= cfg_wdata[0];
      endcase
    end
  end

  // address decode of the held item
  logic [16:0]   idx_ext;
  logic [10:0]   slot_ext;
  logic [AW-1:0] iaddr;
  logic [SW-1:0] saddr;
  logic          idx_ok, slot_ok;

  assign idx_ext  = 17'(item_r.index);
  assign slot_ext = 11'(item_r.slot);
  assign iaddr    = idx_ext[AW-1:0];
  assign saddr    = slot_ext[SW-1:0];
  assign idx_ok   = 32'(item_r.index) < WEIGHT_COUNT;
  assign slot_ok  = 32'(item_r.slot) < BATCH_SLOTS;

  // slot status flops: active doubles as valid bit of the slot memory
  logic [BATCH_SLOTS-1:0] active_v_r;
  logic [BATCH_SLOTS-1:0] flag_v_r;
  logic [CW-1:0]          count_r;
  logic signed [31:0]     bias_accum_r;
  logic                   cur_active, cur_flag;

  assign cur_active = slot_ok & active_v_r[saddr];
  assign cur_flag   = slot_ok & flag_v_r[saddr];

  // memories
  logic signed [31:0] wmem [WEIGHT_COUNT];
  logic signed [31:0] gmem [WEIGHT_COUNT];
  logic [63:0]        smem [BATCH_SLOTS];
  logic signed [31:0] w_q_r, g_q_r;
  logic [63:0]        s_q_r;
  logic               wmem_we, gmem_we, smem_we;
  logic [AW-1:0]      gmem_wa, clr_r;
  logic signed [31:0] gmem_wd;
  logic [63:0]        smem_wd;

  always_ff @(posedge clk) begin
    if (wmem_we) wmem[iaddr] <= item_r.value;
    w_q_r <= wmem[iaddr];
  end

  always_ff @(posedge clk) begin
    if (gmem_we) gmem[gmem_wa] <= gmem_wd;
    g_q_r <= gmem[iaddr];
  end

  always_ff @(posedge clk) begin
    if (smem_we) smem[saddr] <= smem_wd;
    s_q_r <= smem[saddr];
  end

  // datapath registers
  logic signed [31:0] act_r, delta_r, grad_r, g_r, b_r, gv_r;
  logic signed [63:0] prod_r;
  logic               sat_r;

  // values seen in the execute cycle; inactive slots read as zero
  logic signed [31:0] act_cur, delta_cur;
  assign act_cur   = cur_active ? s_q_r[63:32] : 32'sd0;
  assign delta_cur = cur_active ? s_q_r[31:0] : 32'sd0;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_full;
  logic               mul_en;
  assign mul_full = mul_a * mul_b;

  // saturating arithmetic
  srne_pkg::clip_t prod_c, fwd_c, bias_c, delta_c, grad_c, bacc_c, bsum_c;
  assign prod_c  = srne_pkg::sat32(prod_r >>> 16);
  assign fwd_c   = srne_pkg::sat32(64'(act_r) + 64'(prod_c.val));
  assign bias_c  = srne_pkg::sat32(64'(act_r) + 64'(bias_value_r));
  assign delta_c = srne_pkg::sat32(64'(delta_cur) + 64'(item_r.value));
  assign grad_c  = srne_pkg::sat32(64'(grad_r) + 64'(g_r));
  assign bacc_c  = srne_pkg::sat32(64'(bias_accum_r) + 64'(b_r));
  assign bsum_c  = srne_pkg::sat32(64'(bias_value_r) + 64'(bias_accum_r));

  // forward finish: ReLU clamp on the last element
  logic               relu_neg;
  logic signed [31:0] act_fin, delta_fin;
  assign relu_neg  = item_r.last & !act_kind_r & bias_c.val[31];
  assign act_fin   = !item_r.last ? act_r : (relu_neg ? 32'sd0 : bias_c.val);
  assign delta_fin = relu_neg ? 32'sd0 : delta_r;

  logic [7:0] active_slots;
  assign active_slots = (int'(count_r) > 255) ? 8'hFF : 8'(count_r);

  // next state, memory strobes, multiplier operands
  always_comb begin
    state_nxt = state_r;
    wmem_we   = 1'b0;
    gmem_we   = 1'b0;
    gmem_wa   = iaddr;
    gmem_wd   = grad_c.val;
    smem_we   = 1'b0;
    smem_wd   = {act_fin, delta_fin};
    mul_en    = 1'b0;
    mul_a     = delta_r;
    mul_b     = 33'(item_r.value);
    unique case (state_r)
      srne_pkg::ST_CLEAR: begin
        gmem_we = 1'b1;
        gmem_wa = clr_r;
        gmem_wd = '0;
        if (32'(clr_r) == WEIGHT_COUNT - 1) state_nxt = srne_pkg::ST_IDLE;
      end
      srne_pkg::ST_IDLE: begin
        if (start) state_nxt = srne_pkg::ST_READ;
      end
      srne_pkg::ST_READ: begin
        wmem_we = (item_r.mode == srne_pkg::MODE_LOAD) && idx_ok;
        priority if (item_r.mode == srne_pkg::MODE_READ)
          state_nxt = srne_pkg::ST_EXEC;
        else if ((item_r.mode == srne_pkg::MODE_FWD || item_r.mode == srne_pkg::MODE_DELTA ||
                  item_r.mode == srne_pkg::MODE_BWD) && slot_ok)
          state_nxt = srne_pkg::ST_EXEC;
        else
          state_nxt = srne_pkg::ST_IDLE;
      end
      srne_pkg::ST_EXEC: begin
        state_nxt = srne_pkg::ST_IDLE;
        if (item_r.mode == srne_pkg::MODE_FWD) begin
          mul_en    = 1'b1;
          mul_a     = w_q_r;
          state_nxt = srne_pkg::ST_FWD_ADD;
        end else if (item_r.mode == srne_pkg::MODE_DELTA) begin
          smem_we = cur_active && (act_cur > 32'sd0);
          smem_wd = {act_cur, delta_c.val};
        end else if (item_r.mode == srne_pkg::MODE_BWD && cur_active) begin
          mul_en    = 1'b1;
          mul_a     = delta_cur;
          state_nxt = srne_pkg::ST_BK_CLIP1;
        end
      end
      srne_pkg::ST_FWD_ADD: state_nxt = srne_pkg::ST_FWD_END;
      srne_pkg::ST_FWD_END: begin
        smem_we   = 1'b1;
        state_nxt = srne_pkg::ST_IDLE;
      end
      srne_pkg::ST_BK_CLIP1: state_nxt = adam_r ? srne_pkg::ST_BK_GRAD : srne_pkg::ST_BK_MUL2;
      srne_pkg::ST_BK_MUL2: begin
        mul_en    = 1'b1;
        mul_a     = g_r;
        mul_b     = signed'({9'b0, lrate_r});
        state_nxt = srne_pkg::ST_BK_CLIP2;
      end
      srne_pkg::ST_BK_CLIP2: state_nxt = srne_pkg::ST_BK_GRAD;
      srne_pkg::ST_BK_GRAD: begin
        gmem_we = idx_ok;
        mul_en  = item_r.last && !adam_r;
        mul_b   = signed'({9'b0, lrate_r});
        priority if (!item_r.last) state_nxt = srne_pkg::ST_IDLE;
        else if (adam_r)           state_nxt = srne_pkg::ST_BK_BIAS;
        else                       state_nxt = srne_pkg::ST_BK_CLIPB;
      end
      srne_pkg::ST_BK_CLIPB: state_nxt = srne_pkg::ST_BK_BIAS;
      srne_pkg::ST_BK_BIAS:  state_nxt = srne_pkg::ST_BK_OUT;
      srne_pkg::ST_BK_OUT:   state_nxt = srne_pkg::ST_IDLE;
      default:               state_nxt = srne_pkg::ST_IDLE;
    endcase
  end

  // state register and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srne_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == srne_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (state_r == srne_pkg::ST_IDLE && start) item_r <= in_item;
  end

  // control state: slot status, counters, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_v_r   <= '0;
      flag_v_r     <= '0;
      count_r      <= '0;
      bias_accum_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        srne_pkg::ST_EXEC: begin
          if (item_r.mode == srne_pkg::MODE_FWD && !cur_active) begin
            active_v_r[saddr] <= 1'b1;
            count_r           <= count_r + 1'b1;
          end
          if (item_r.mode == srne_pkg::MODE_READ) out_valid_r <= 1'b1;
        end
        srne_pkg::ST_FWD_END: begin
          if (item_r.last) begin
            out_valid_r <= 1'b1;
            if (!act_kind_r) flag_v_r[saddr] <= relu_neg;
          end
        end
        srne_pkg::ST_BK_BIAS: begin
          bias_accum_r      <= bacc_c.val;
          active_v_r[saddr] <= 1'b0;
          count_r           <= count_r - 1'b1;
        end
        srne_pkg::ST_BK_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_full[63:0];
    unique case (state_r)
      srne_pkg::ST_EXEC: begin
        act_r   <= item_r.first ? 32'sd0 : act_cur;
        delta_r <= delta_cur;
        grad_r  <= g_q_r;
        sat_r   <= (item_r.mode == srne_pkg::MODE_DELTA) ? delta_c.sat : 1'b0;
        out_r   <= '{activation: 32'sd0, gradient_flag: 1'b0,
                     gradient_value: idx_ok ? g_q_r : 32'sd0, bias_sum: bsum_c.val,
                     active_slots: active_slots, saturated: 1'b0};
      end
      srne_pkg::ST_FWD_ADD: begin
        if (idx_ok) begin
          act_r <= fwd_c.val;
          sat_r <= prod_c.sat | fwd_c.sat;
        end
      end
      srne_pkg::ST_FWD_END: begin
        out_r <= '{activation: act_fin,
                   gradient_flag: act_kind_r ? cur_flag : relu_neg,
                   gradient_value: 32'sd0, bias_sum: bsum_c.val,
                   active_slots: active_slots,
                   saturated: sat_r | (item_r.last & bias_c.sat)};
      end
      srne_pkg::ST_BK_CLIP1, srne_pkg::ST_BK_CLIP2: begin
        g_r   <= prod_c.val;
        sat_r <= sat_r | prod_c.sat;
      end
      srne_pkg::ST_BK_GRAD: begin
        gv_r <= idx_ok ? grad_c.val : 32'sd0;
        if (idx_ok) sat_r <= sat_r | grad_c.sat;
        b_r <= delta_r;
      end
      srne_pkg::ST_BK_CLIPB: begin
        b_r   <= prod_c.val;
        sat_r <= sat_r | prod_c.sat;
      end
      srne_pkg::ST_BK_BIAS: sat_r <= sat_r | bacc_c.sat;
      srne_pkg::ST_BK_OUT: begin
        out_r <= '{activation: 32'sd0, gradient_flag: 1'b0, gradient_value: gv_r,
                   bias_sum: bsum_c.val, active_slots: active_slots, saturated: sat_r};
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != srne_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= BATCH_SLOTS) else $error("active slot count overflow");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without an item in flight");

endmodule

`default_nettype wire
